// ===== design/device_slot_registry_with_timers_assert.svh =====
// Assertion macros for the device slot registry.
// Every macro samples on i_clk and is disabled while i_rst_n is low.
`ifndef DEVICE_SLOT_REGISTRY_WITH_TIMERS_ASSERT_SVH
`define DEVICE_SLOT_REGISTRY_WITH_TIMERS_ASSERT_SVH

// Check a condition at every clock edge.
`define DSRT_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define DSRT_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (trig) |=> (cons)) else $error(msg);

`endif

// ===== design/dsrt_pkg.sv =====
// Shared types, codes and constants for the device slot registry.
// No dependencies.
package dsrt_pkg;

    localparam int SLOTS_PER_TYPE_DEF = 5;
    localparam int TIMER_BITS_DEF     = 16;
    localparam int TYPE_COUNT         = 4;

    localparam int ADDR_W  = 7;
    localparam int TYPE_W  = 2;
    localparam int SLOT_IW = 3;
    localparam int LEASE_W = 16;

    // Address ranges per device type
    localparam logic [ADDR_W-1:0] T0_LO = 7'h60;
    localparam logic [ADDR_W-1:0] T0_HI = 7'h70;
    localparam logic [ADDR_W-1:0] T1_LO = 7'h00;
    localparam logic [ADDR_W-1:0] T1_HI = 7'h0f;
    localparam logic [ADDR_W-1:0] T2_LO = 7'h20;
    localparam logic [ADDR_W-1:0] T2_HI = 7'h30;
    localparam logic [ADDR_W-1:0] T3_LO = 7'h40;
    localparam logic [ADDR_W-1:0] T3_HI = 7'h50;

    localparam logic [ADDR_W-1:0] ADDR_EMPTY = '0;

    typedef enum logic [1:0] {
        MODE_ADD    = 2'd0,
        MODE_REMOVE = 2'd1,
        MODE_KICK   = 2'd2,
        MODE_TICK   = 2'd3
    } t_mode;

    typedef struct packed {
        t_mode                mode;
        logic [ADDR_W-1:0]    dev_addr;
        logic [TYPE_W-1:0]    dev_type;
        logic [SLOT_IW-1:0]   slot_index;
        logic [LEASE_W-1:0]   lease_ticks;
    } t_in;

    typedef struct packed {
        logic                 ok;
        logic [TYPE_W-1:0]    got_type;
        logic [SLOT_IW-1:0]   got_slot;
        logic [ADDR_W-1:0]    old_addr;
    } t_out;

    typedef struct packed {
        logic              hit;
        logic [TYPE_W-1:0] dtype;
    } t_class;

    // Sort an address into its type row; address zero never matches.
    function automatic t_class classify(input logic [ADDR_W-1:0] a);
        t_class c;
        c = '{hit: 1'b1, dtype: 2'd0};
        if (a >= T0_LO && a <= T0_HI) begin
            c.dtype = 2'd0;
        end else if (a > T1_LO && a <= T1_HI) begin
            c.dtype = 2'd1;
        end else if (a >= T2_LO && a <= T2_HI) begin
            c.dtype = 2'd2;
        end else if (a >= T3_LO && a <= T3_HI) begin
            c.dtype = 2'd3;
        end else begin
            c.hit = 1'b0;
        end
        return c;
    endfunction

endpackage

// ===== design/device_slot_registry_with_timers.sv =====
// Device slot registry with per-slot lease timers; top level.
// Depends on dsrt_pkg and device_slot_registry_with_timers_assert.svh.
//
// Usage: one beat on the input channel (i_in_valid / o_in_stall, payload
// i_in_data) carries one operation: add an address, remove a slot, kick a
// slot's lease timer, or tick all timers. Each beat yields exactly one result
// beat on the output channel (o_out_valid / i_out_stall, payload o_out_data).
// The table and timers update, and the result register loads, at the edge that
// accepts the beat. Throughput is one beat per cycle while the receiver does
// not stall, set by the single result register; the first-free search over
// one type row and the parallel timer decrements all fit between input and
// that register. While the receiver stalls, the result holds and a new beat
// is taken only in the cycle the waiting result leaves; o_in_stall is high
// exactly when a result waits and the receiver stalls.
// Reset (synchronous, active low) empties every slot, clears every timer and
// drops any waiting result.
`include "device_slot_registry_with_timers_assert.svh"

module device_slot_registry_with_timers #(
    parameter int SLOTS_PER_TYPE = dsrt_pkg::SLOTS_PER_TYPE_DEF,
    parameter int TIMER_BITS     = dsrt_pkg::TIMER_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dsrt_pkg::t_in  i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dsrt_pkg::t_out o_out_data
);
    import dsrt_pkg::*;

    // Slot index width inside a row
    localparam int SLOT_W = (SLOTS_PER_TYPE > 1) ? $clog2(SLOTS_PER_TYPE) : 1;
    // Largest timer value, kept one bit wider so 32-bit timers still work
    localparam logic [32:0] TMAX_WIDE = (33'd1 << TIMER_BITS) - 33'd1;

    // Slot table and lease timers: one row per device type
    logic [ADDR_W-1:0]     r_slot_addr [TYPE_COUNT][SLOTS_PER_TYPE];
    logic [ADDR_W-1:0]     n_slot_addr [TYPE_COUNT][SLOTS_PER_TYPE];
    logic [TIMER_BITS-1:0] r_lease     [TYPE_COUNT][SLOTS_PER_TYPE];
    logic [TIMER_BITS-1:0] n_lease     [TYPE_COUNT][SLOTS_PER_TYPE];

    // Result register
    logic r_out_valid;
    logic n_out_valid;
    t_out r_out_data;
    t_out n_out_data;

    logic                  in_acc;
    t_class                cls;
    logic                  free_found;
    logic [SLOT_W-1:0]     free_slot;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot_sel;
    logic [ADDR_W-1:0]     sel_addr;
    logic [TIMER_BITS-1:0] lease_sat;

    // Take a beat unless a result is waiting on a stalled receiver
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    assign cls      = classify(i_in_data.dev_addr);
    assign slot_ok  = 32'(i_in_data.slot_index) < SLOTS_PER_TYPE;
    assign slot_sel = SLOT_W'(i_in_data.slot_index);
    assign sel_addr = r_slot_addr[i_in_data.dev_type][slot_sel];

    // Saturate the requested lease to the timer width
    always_comb begin
        if (33'(i_in_data.lease_ticks) > TMAX_WIDE) begin
            lease_sat = TMAX_WIDE[TIMER_BITS-1:0];
        end else begin
            lease_sat = TIMER_BITS'(i_in_data.lease_ticks);
        end
    end

    // First free slot in the row the address sorts into; lowest index wins
    always_comb begin
        free_found = 1'b0;
        free_slot  = '0;
        for (int s = SLOTS_PER_TYPE - 1; s >= 0; s--) begin
            if (r_slot_addr[cls.dtype][s] == ADDR_EMPTY) begin
                free_found = 1'b1;
                free_slot  = SLOT_W'(s);
            end
        end
    end

    // Table and timer updates for the accepted beat
    always_comb begin
        n_slot_addr = r_slot_addr;
        n_lease     = r_lease;
        if (in_acc) begin
            case (i_in_data.mode)
                MODE_ADD: begin
                    if (cls.hit && free_found) begin
                        n_slot_addr[cls.dtype][free_slot] = i_in_data.dev_addr;
                    end
                end
                MODE_REMOVE: begin
                    // timer keeps running on purpose
                    if (slot_ok) begin
                        n_slot_addr[i_in_data.dev_type][slot_sel] = ADDR_EMPTY;
                    end
                end
                MODE_KICK: begin
                    if (slot_ok && sel_addr != ADDR_EMPTY) begin
                        n_lease[i_in_data.dev_type][slot_sel] = lease_sat;
                    end
                end
                MODE_TICK: begin
                    for (int t = 0; t < TYPE_COUNT; t++) begin
                        for (int s = 0; s < SLOTS_PER_TYPE; s++) begin
                            if (r_lease[t][s] != '0) begin
                                n_lease[t][s] = r_lease[t][s] - 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Result for the accepted beat
    always_comb begin
        n_out_data = '{ok: 1'b0, got_type: i_in_data.dev_type,
                       got_slot: i_in_data.slot_index, old_addr: ADDR_EMPTY};
        case (i_in_data.mode)
            MODE_ADD: begin
                n_out_data.got_type = cls.hit ? cls.dtype : 2'd0;
                n_out_data.got_slot = (cls.hit && free_found) ?
                                      SLOT_IW'(free_slot) : '0;
                n_out_data.ok       = cls.hit && free_found;
            end
            MODE_REMOVE: begin
                n_out_data.ok       = slot_ok;
                n_out_data.old_addr = slot_ok ? sel_addr : ADDR_EMPTY;
            end
            MODE_KICK: begin
                n_out_data.ok = slot_ok && sel_addr != ADDR_EMPTY;
            end
            MODE_TICK: begin
                n_out_data.ok = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // Load on accept, drop once the receiver takes the result
    always_comb begin
        if (in_acc) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int t = 0; t < TYPE_COUNT; t++) begin
                for (int s = 0; s < SLOTS_PER_TYPE; s++) begin
                    r_slot_addr[t][s] <= ADDR_EMPTY;
                    r_lease[t][s]     <= '0;
                end
            end
        end else begin
            r_out_valid <= n_out_valid;
            r_slot_addr <= n_slot_addr;
            r_lease     <= n_lease;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_out_data <= n_out_data;
        end
    end

    `DSRT_ASSERT_ALWAYS(a_stall_only_when_full, !o_in_stall || o_out_valid,
        "input stalled with no result waiting")
    `DSRT_ASSERT_NEXT(a_accept_gives_result, in_acc, o_out_valid,
        "accepted beat produced no result")
    `DSRT_ASSERT_NEXT(a_zero_addr_rejected,
        in_acc && i_in_data.mode == MODE_ADD && i_in_data.dev_addr == ADDR_EMPTY,
        !o_out_data.ok, "add of the empty address was accepted")
    `DSRT_ASSERT_NEXT(a_tick_result, in_acc && i_in_data.mode == MODE_TICK,
        o_out_data.ok && o_out_data.old_addr == ADDR_EMPTY,
        "tick result malformed")

endmodule

// ===== sim/tb_device_slot_registry_with_timers.sv =====
// Self-checking bench for the device slot registry with lease timers.
// Depends on dsrt_pkg and the device_slot_registry_with_timers RTL.
// Directed and random operations with a local copy of the slot table and timers.
module tb_device_slot_registry_with_timers;
    import dsrt_pkg::*;

    localparam int SLOT_COUNT = SLOTS_PER_TYPE_DEF;
    localparam int TMR_W      = TIMER_BITS_DEF;
    localparam int ENTRIES    = TYPE_COUNT * SLOT_COUNT;
    localparam longint unsigned TMR_MAX = (64'd1 << TMR_W) - 1;
    localparam int LONG_HOLD  = 80;     // receiver hold-off during back pressure
    localparam int MAX_REPORTS = 40;    // cap on printed mismatch lines

    logic   clk;
    logic   rst_n;
    logic   in_valid;
    logic   in_stall;
    t_in    in_data;
    logic   out_valid;
    logic   out_stall;
    t_out   out_data;

    // Bench controls; the tests write idle_en and rx_hold with nonblocking assignments.
    bit     idle_en;
    bit     rx_hold;
    int     rx_wait;

    // Local copy of the block's state.
    logic [ADDR_W-1:0] slot_tbl  [ENTRIES];
    logic [TMR_W-1:0]  lease_tmr [ENTRIES];

    // Results still owed by the block, oldest first.
    t_out   owed_results[$];
    int     mismatches;

    device_slot_registry_with_timers #(
        .SLOTS_PER_TYPE (SLOT_COUNT),
        .TIMER_BITS     (TMR_W)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // Give up if the run stalls: far beyond the slowest legal run.
    initial begin
        #1000000;
        $display("*** FAILED ***");
        $finish;
    end

    // Apply one operation to the local table and return the result it owes.
    function automatic t_out predict_result(input t_in b);
        t_out r;
        int   row;
        int   k;
        r = '{ok: 1'b0, got_type: b.dev_type, got_slot: b.slot_index, old_addr: ADDR_EMPTY};
        case (b.mode)
            MODE_ADD: begin
                r.got_type = '0;
                r.got_slot = '0;
                // Sort by fixed ranges; address zero never lands in the type 1 row.
                if (b.dev_addr >= T0_LO && b.dev_addr <= T0_HI) row = 0;
                else if (b.dev_addr > T1_LO && b.dev_addr <= T1_HI) row = 1;
                else if (b.dev_addr >= T2_LO && b.dev_addr <= T2_HI) row = 2;
                else if (b.dev_addr >= T3_LO && b.dev_addr <= T3_HI) row = 3;
                else row = -1;
                if (row >= 0) begin
                    r.got_type = row[TYPE_W-1:0];
                    // Take the first free slot of the row; a full row leaves ok low.
                    for (int i = 0; i < SLOT_COUNT; i++) begin
                        k = row * SLOT_COUNT + i;
                        if (!r.ok && slot_tbl[k] == ADDR_EMPTY) begin
                            slot_tbl[k] = b.dev_addr;
                            r.got_slot  = i[SLOT_IW-1:0];
                            r.ok        = 1'b1;
                        end
                    end
                end
            end
            MODE_REMOVE: begin
                // Clear the slot, hand back what it held; the timer keeps running.
                if (b.slot_index < SLOT_COUNT) begin
                    k = b.dev_type * SLOT_COUNT + b.slot_index;
                    r.old_addr  = slot_tbl[k];
                    slot_tbl[k] = ADDR_EMPTY;
                    r.ok        = 1'b1;
                end
            end
            MODE_KICK: begin
                // Load the timer of an occupied slot only; saturate a wide lease.
                if (b.slot_index < SLOT_COUNT) begin
                    k = b.dev_type * SLOT_COUNT + b.slot_index;
                    if (slot_tbl[k] != ADDR_EMPTY) begin
                        lease_tmr[k] = (b.lease_ticks > TMR_MAX) ? '1 : b.lease_ticks;
                        r.ok = 1'b1;
                    end
                end
            end
            default: begin
                // Tick: count every running timer down, stop at zero.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (lease_tmr[i] != '0) lease_tmr[i] = lease_tmr[i] - 1'b1;
                end
                r.ok = 1'b1;
            end
        endcase
        return r;
    endfunction

    function automatic t_in make_op(input t_mode m, input logic [ADDR_W-1:0] a,
                                    input logic [TYPE_W-1:0] ty,
                                    input logic [SLOT_IW-1:0] s,
                                    input logic [LEASE_W-1:0] l);
        t_in b;
        b.mode        = m;
        b.dev_addr    = a;
        b.dev_type    = ty;
        b.slot_index  = s;
        b.lease_ticks = l;
        return b;
    endfunction

    // Random operation; add_pct steers the table toward full or empty rows.
    function automatic t_in random_op(input int add_pct);
        t_in b;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < add_pct) begin
            b.mode = MODE_ADD;
        end else begin
            pick = $urandom_range(0, 99);
            b.mode = (pick < 35) ? MODE_REMOVE : (pick < 70) ? MODE_KICK : MODE_TICK;
        end
        // Mostly addresses inside a type range, some zero, some anywhere.
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
            b.dev_addr = ADDR_EMPTY;
        end else if (pick < 4) begin
            b.dev_addr = ADDR_W'($urandom_range(0, 127));
        end else begin
            case ($urandom_range(0, 3))
                0:       b.dev_addr = ADDR_W'($urandom_range(T0_LO, T0_HI));
                1:       b.dev_addr = ADDR_W'($urandom_range(T1_LO + 1, T1_HI));
                2:       b.dev_addr = ADDR_W'($urandom_range(T2_LO, T2_HI));
                default: b.dev_addr = ADDR_W'($urandom_range(T3_LO, T3_HI));
            endcase
        end
        b.dev_type   = TYPE_W'($urandom_range(0, TYPE_COUNT - 1));
        b.slot_index = ($urandom_range(0, 9) == 0) ?
                       SLOT_IW'($urandom_range(SLOT_COUNT, 7)) :
                       SLOT_IW'($urandom_range(0, SLOT_COUNT - 1));
        pick = $urandom_range(0, 9);
        b.lease_ticks = (pick == 0) ? '0 : (pick == 1) ? '1 :
                        LEASE_W'($urandom_range(0, 16'hFFFF));
        return b;
    endfunction

    // Offer one beat, after a random gap when idle_en is set; hold it until the block takes it.
    // Valid stays high across back-to-back beats.
    task automatic send_beat(input t_in b);
        int gap;
        gap = idle_en ? $urandom_range(0, 9) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        do @(posedge clk); while (in_stall !== 1'b0);
        owed_results.push_back(predict_result(b));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_results_done();
        in_valid <= 1'b0;
        while (owed_results.size() > 0) @(posedge clk);
    endtask

    // Receiver: check each result beat against the oldest owed result,
    // then draw a stall for the next one. A long hold overrides the draw.
    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (owed_results.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result beat %p", $time, out_data);
            end else begin
                t_out want;
                want = owed_results.pop_front();
                if (out_data.ok !== want.ok) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: ok expected %0d actual %0d",
                                 $time, want.ok, out_data.ok);
                end
                if (out_data.got_type !== want.got_type) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: got_type expected %0d actual %0d",
                                 $time, want.got_type, out_data.got_type);
                end
                if (out_data.got_slot !== want.got_slot) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: got_slot expected %0d actual %0d",
                                 $time, want.got_slot, out_data.got_slot);
                end
                if (out_data.old_addr !== want.old_addr) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: old_addr expected 0x%0h actual 0x%0h",
                                 $time, want.old_addr, out_data.old_addr);
                end
            end
            rx_wait = idle_en ? $urandom_range(0, 9) : 0;
        end
        if (rx_hold) begin
            out_stall <= 1'b1;
        end else if (rx_wait > 0) begin
            out_stall <= 1'b1;
            rx_wait--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Address rules: zero, gaps between ranges, every range edge,
    // a repeated address and a full row.
    task automatic test_add_rules();
        send_beat(make_op(MODE_ADD, 7'h00, 2'd3, 3'd7, 16'hFFFF));
        send_beat(make_op(MODE_ADD, 7'h7F, 2'd3, 3'd7, 16'hFFFF));
        send_beat(make_op(MODE_ADD, 7'h10, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, 7'h1F, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T0_LO, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T0_HI, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, 7'h01, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T1_HI, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T2_LO, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T2_HI, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T3_LO, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T3_HI, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, T0_LO, 2'd0, 3'd0, 16'h0000));
        // Fill the type 1 row, then try once more.
        send_beat(make_op(MODE_ADD, 7'h02, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, 7'h03, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, 7'h04, 2'd0, 3'd0, 16'h0000));
        send_beat(make_op(MODE_ADD, 7'h05, 2'd0, 3'd0, 16'h0000));
    endtask

    // Kick and remove on occupied, empty and out-of-range slots, then a tick
    // and a re-add that must reuse the freed slot.
    task automatic test_remove_kick();
        send_beat(make_op(MODE_KICK,   7'h00, 2'd1, 3'd0, 16'hFFFF));
        send_beat(make_op(MODE_KICK,   7'h7F, 2'd3, 3'd4, 16'h1234));
        send_beat(make_op(MODE_KICK,   7'h00, 2'd1, 3'd7, 16'h0001));
        send_beat(make_op(MODE_KICK,   7'h00, 2'd0, 3'd1, 16'h0000));
        send_beat(make_op(MODE_REMOVE, 7'h00, 2'd1, 3'd2, 16'h0000));
        send_beat(make_op(MODE_REMOVE, 7'h00, 2'd1, 3'd2, 16'h0000));
        send_beat(make_op(MODE_REMOVE, 7'h00, 2'd2, 3'd5, 16'h0000));
        send_beat(make_op(MODE_TICK,   7'h7F, 2'd3, 3'd7, 16'hFFFF));
        send_beat(make_op(MODE_ADD,    7'h0E, 2'd0, 3'd0, 16'h0000));
    endtask

    // Long random traffic in phases: fill rows, empty them, then a mix.
    task automatic test_random_traffic();
        repeat (400) send_beat(random_op(60));
        repeat (350) send_beat(random_op(15));
        repeat (250) send_beat(random_op(35));
    endtask

    // Sender pauses mid-stream until every owed result is back.
    task automatic test_pause_until_empty();
        repeat (100) send_beat(random_op(40));
        wait_results_done();
        repeat (100) send_beat(random_op(40));
    endtask

    // Back-to-back beats with both sides idle-free.
    task automatic test_no_idle_burst();
        idle_en <= 1'b0;
        repeat (150) send_beat(random_op(35));
        idle_en <= 1'b1;
    endtask

    // Receiver holds off for a long stretch in its own process while the
    // sender keeps offering, so the block fills and stalls its input.
    task automatic test_back_pressure();
        fork
            begin
                rx_hold <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
                rx_hold <= 1'b0;
            end
        join_none
        repeat (120) send_beat(random_op(40));
        wait_results_done();
    endtask

    initial begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        idle_en    = 1'b1;
        rx_hold    = 1'b0;
        rx_wait    = 0;
        mismatches = 0;
        for (int i = 0; i < ENTRIES; i++) begin
            slot_tbl[i]  = ADDR_EMPTY;
            lease_tmr[i] = '0;
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_add_rules();
        test_remove_kick();
        test_random_traffic();
        test_pause_until_empty();
        test_no_idle_burst();
        test_back_pressure();

        // Drain, then wait for any stray beat to show up.
        wait_results_done();
        repeat (5) @(posedge clk);
        if (mismatches == 0 && owed_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
